### sv/msmd_pkg.sv
package msmd_pkg;

  // Pattern geometry
  localparam int LONGEST_PATTERN = 11;
  localparam int PAT_COUNT       = 6;
  localparam int POS_W           = 4;
  localparam int DEVICE_ID_POS   = 2;

  // Configuration register map (byte addresses 4*i)
  localparam int CFG_ADDR_W = 3;
  localparam logic REG_STANDARD_LOCKED  = 1'b0;
  localparam logic REG_DEFAULT_STANDARD = 1'b1;

  typedef enum logic [1:0] {
    STD_GM = 2'd0,
    STD_GS = 2'd1,
    STD_XG = 2'd2
  } std_t;

  // Pattern indexes
  localparam logic [2:0] PAT_GM_ON   = 3'd0;
  localparam logic [2:0] PAT_GM_OFF  = 3'd1;
  localparam logic [2:0] PAT_GS_RST  = 3'd2;
  localparam logic [2:0] PAT_GS_SET1 = 3'd3;
  localparam logic [2:0] PAT_GS_SET2 = 3'd4;
  localparam logic [2:0] PAT_XG_ON   = 3'd5;

  localparam logic [POS_W-1:0] PAT_LEN [PAT_COUNT] = '{
    4'd6, 4'd6, 4'd11, 4'd11, 4'd11, 4'd9
  };

  localparam logic [PAT_COUNT-1:0] ALL_ALIVE = '1;

  // Per-step update handed from the matcher to the state registers
  typedef struct packed {
    logic [POS_W-1:0]     pos;
    logic [PAT_COUNT-1:0] alive;
    std_t                 standard;
    logic                 recognized;
  } msmd_step_t;

  // Expected byte of pattern k at position pos (device ID position is a don't care)
  function automatic logic [7:0] pat_byte(input logic [2:0] k, input logic [POS_W-1:0] pos);
    logic [7:0] b;
    b = 8'h00;
    case (pos)
      4'd0:  b = 8'hf0;
      4'd1: begin
        case (k)
          PAT_GM_ON, PAT_GM_OFF:                b = 8'h7e;
          PAT_GS_RST, PAT_GS_SET1, PAT_GS_SET2: b = 8'h41;
          default:                              b = 8'h43;
        endcase
      end
      4'd3: begin
        case (k)
          PAT_GM_ON, PAT_GM_OFF:                b = 8'h09;
          PAT_GS_RST, PAT_GS_SET1, PAT_GS_SET2: b = 8'h42;
          default:                              b = 8'h4c;
        endcase
      end
      4'd4: begin
        case (k)
          PAT_GM_ON:  b = 8'h01;
          PAT_GM_OFF: b = 8'h02;
          PAT_XG_ON:  b = 8'h00;
          default:    b = 8'h12;
        endcase
      end
      4'd5: begin
        case (k)
          PAT_GM_ON, PAT_GM_OFF: b = 8'hf7;
          PAT_GS_RST:            b = 8'h40;
          default:               b = 8'h00;
        endcase
      end
      4'd6: b = (k == PAT_XG_ON) ? 8'h7e : 8'h00;
      4'd7: b = (k == PAT_XG_ON) ? 8'h00 : 8'h7f;
      4'd8: begin
        case (k)
          PAT_GS_SET2: b = 8'h01;
          PAT_XG_ON:   b = 8'hf7;
          default:     b = 8'h00;
        endcase
      end
      4'd9: begin
        case (k)
          PAT_GS_RST:  b = 8'h41;
          PAT_GS_SET1: b = 8'h01;
          default:     b = 8'h00;
        endcase
      end
      4'd10:   b = 8'hf7;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

### sv/msmd_stream_if.sv
interface msmd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] sysex_byte;
  logic       last_byte;

  modport source (output valid, output sysex_byte, output last_byte, input ready);
  modport sink   (input valid, input sysex_byte, input last_byte, output ready);
endinterface

interface msmd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] midi_standard;
  logic       recognized;

  modport source (output valid, output midi_standard, output recognized, input ready);
  modport sink   (input valid, input midi_standard, input recognized, output ready);
endinterface

### sv/msmd_matcher.sv
module msmd_matcher
  import msmd_pkg::*;
(
  input  logic [7:0]           sysex_byte,
  input  logic                 last_byte,
  input  logic [POS_W-1:0]     pos,
  input  logic [PAT_COUNT-1:0] alive,
  input  logic                 locked,
  input  std_t                 default_std,
  input  std_t                 cur_std,
  output msmd_step_t           step
);

  logic [PAT_COUNT-1:0] alive_nxt;
  logic [PAT_COUNT-1:0] done;
  logic [POS_W:0]       pos_inc;

  assign pos_inc = {1'b0, pos} + {{POS_W{1'b0}}, 1'b1};

  // Compare this byte against every live pattern
  always_comb begin
    for (int k = 0; k < PAT_COUNT; k++) begin
      alive_nxt[k] = alive[k]
                     && ({1'b0, pos} < (POS_W+1)'(LONGEST_PATTERN))
                     && (pos < PAT_LEN[k])
                     && ((pos == POS_W'(DEVICE_ID_POS)) || (sysex_byte == pat_byte(3'(k), pos)));
      done[k] = alive_nxt[k] && (pos_inc == {1'b0, PAT_LEN[k]});
    end
  end

  // Build the state update and result for this beat
  always_comb begin
    step.standard   = cur_std;
    step.recognized = 1'b0;
    if (last_byte) begin
      step.pos   = '0;
      step.alive = ALL_ALIVE;
      if (|done) begin
        step.recognized = 1'b1;
        if (!locked) begin
          if (done[PAT_GM_ON])        step.standard = STD_GM;
          else if (done[PAT_GM_OFF])  step.standard = default_std;
          else if (done[PAT_GS_RST] || done[PAT_GS_SET1] || done[PAT_GS_SET2])
                                      step.standard = STD_GS;
          else                        step.standard = STD_XG;
        end
      end
    end else begin
      step.pos   = ({1'b0, pos} < (POS_W+1)'(LONGEST_PATTERN)) ? pos_inc[POS_W-1:0] : pos;
      step.alive = alive_nxt;
    end
  end

endmodule

### sv/midi_sysex_mode_detector_core.sv
// An accepted input beat waits in the input register, then moves to the result register, which offers it.
// Throughput: one byte per cycle; the input register advances whenever the
// result register is empty or is being taken in the same cycle.
// Reset (synchronous, rst_n low): standard GM, position 0, all patterns live,
// lock and default registers cleared, both pipeline registers empty.
module midi_sysex_mode_detector_core
  import msmd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  msmd_in_if.sink               in_bus,
  msmd_out_if.source            out_bus,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  logic                 s0_valid_r;
  logic [7:0]           s0_byte_r;
  logic                 s0_last_r;
  logic                 out_valid_r;
  std_t                 out_std_r;
  logic                 out_rec_r;
  logic                 locked_r;
  std_t                 default_r;
  std_t                 cur_std_r;
  logic [POS_W-1:0]     pos_r;
  logic [PAT_COUNT-1:0] alive_r;

  logic       s0_adv;
  logic       in_take;
  logic       cfg_wr;
  logic       cfg_idx;
  logic [1:0] wr_std;
  msmd_step_t step;

  // Handshake: advance the input register into a free or draining result register
  assign s0_adv       = s0_valid_r && (!out_valid_r || out_bus.ready);
  assign in_bus.ready = !s0_valid_r || s0_adv;
  assign in_take      = in_bus.valid && in_bus.ready;

  assign out_bus.valid         = out_valid_r;
  assign out_bus.midi_standard = out_std_r;
  assign out_bus.recognized    = out_rec_r;

  // Configuration access
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite
                      && (cfg_paddr[CFG_ADDR_W-1:2] == 1'b0 || cfg_paddr[CFG_ADDR_W-1:2] == 1'b1);
  assign wr_std     = (cfg_pwdata[1:0] == 2'd3) ? 2'(STD_XG) : cfg_pwdata[1:0];

  always_comb begin
    case (cfg_idx)
      REG_STANDARD_LOCKED:  cfg_prdata = {31'd0, locked_r};
      REG_DEFAULT_STANDARD: cfg_prdata = {30'd0, default_r};
      default:              cfg_prdata = '0;
    endcase
  end

  msmd_matcher u_matcher (
    .sysex_byte  (s0_byte_r),
    .last_byte   (s0_last_r),
    .pos         (pos_r),
    .alive       (alive_r),
    .locked      (locked_r),
    .default_std (default_r),
    .cur_std     (cur_std_r),
    .step        (step)
  );

  // Input register: hold the accepted beat until it moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (in_bus.ready) begin
      s0_valid_r <= in_take;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s0_byte_r <= in_bus.sysex_byte;
      s0_last_r <= in_bus.last_byte;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s0_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_adv) begin
      out_std_r <= step.standard;
      out_rec_r <= step.recognized;
    end
  end

  // Message tracking and standard state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      locked_r  <= 1'b0;
      default_r <= STD_GM;
      cur_std_r <= STD_GM;
      pos_r     <= '0;
      alive_r   <= ALL_ALIVE;
    end else begin
      if (s0_adv) begin
        cur_std_r <= step.standard;
        pos_r     <= step.pos;
        alive_r   <= step.alive;
      end
      if (cfg_wr) begin
        case (cfg_idx)
          REG_STANDARD_LOCKED: locked_r <= cfg_pwdata[0];
          REG_DEFAULT_STANDARD: begin
            default_r <= std_t'(wr_std);
            cur_std_r <= std_t'(wr_std);
          end
          default: ;
        endcase
      end
    end
  end

endmodule

### dv/midi_mode_monitor.sv
`timescale 1ns / 100ps

module midi_mode_monitor
  import msmd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  msmd_in_if                    in_bus,
  msmd_out_if                   out_bus,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic                  cfg_pready,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output int                    fail_count,
  output int                    pending_results,
  output int                    results_checked,
  output int                    matches_seen
);

  typedef struct packed {
    std_t standard;
    logic recognized;
  } mode_result_t;

  // Message bytes per pattern; the device ID slot is never compared
  localparam logic [7:0] SYSEX_TABLE [PAT_COUNT][LONGEST_PATTERN] = '{
    '{8'hf0, 8'h7e, 8'h00, 8'h09, 8'h01, 8'hf7, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'hf0, 8'h7e, 8'h00, 8'h09, 8'h02, 8'hf7, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'hf0, 8'h41, 8'h00, 8'h42, 8'h12, 8'h40, 8'h00, 8'h7f, 8'h00, 8'h41, 8'hf7},
    '{8'hf0, 8'h41, 8'h00, 8'h42, 8'h12, 8'h00, 8'h00, 8'h7f, 8'h00, 8'h01, 8'hf7},
    '{8'hf0, 8'h41, 8'h00, 8'h42, 8'h12, 8'h00, 8'h00, 8'h7f, 8'h01, 8'h00, 8'hf7},
    '{8'hf0, 8'h43, 8'h00, 8'h4c, 8'h00, 8'h00, 8'h7e, 8'h00, 8'hf7, 8'h00, 8'h00}
  };

  logic                 lock_q;
  std_t                 default_std;
  std_t                 current_std;
  logic [POS_W-1:0]     byte_pos;
  logic [PAT_COUNT-1:0] live_mask;
  mode_result_t         expected_modes [$];

  task automatic flag_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    fail_count++;
  endtask

  // Advance the pattern matcher by one byte and return the result it implies
  task automatic advance_detector(input logic [7:0] b, input logic last,
                                  output mode_result_t res);
    logic [PAT_COUNT-1:0] live;
    logic [PAT_COUNT-1:0] done;
    live = live_mask;
    done = '0;
    for (int k = 0; k < PAT_COUNT; k++) begin
      if (live[k]) begin
        if (byte_pos >= LONGEST_PATTERN || byte_pos >= PAT_LEN[k]) begin
          live[k] = 1'b0;
        end else if (byte_pos != DEVICE_ID_POS && b != SYSEX_TABLE[k][byte_pos]) begin
          live[k] = 1'b0;
        end
      end
    end
    res.recognized = 1'b0;
    if (last) begin
      for (int k = 0; k < PAT_COUNT; k++) begin
        if (live[k] && (byte_pos + 1) == PAT_LEN[k]) done[k] = 1'b1;
      end
      if (done != '0) begin
        res.recognized = 1'b1;
        // a locked standard still reports the match but holds its value
        if (!lock_q) begin
          if (done[PAT_GM_ON]) begin
            current_std = STD_GM;
          end else if (done[PAT_GM_OFF]) begin
            current_std = default_std;
          end else if (done[PAT_GS_RST] || done[PAT_GS_SET1] || done[PAT_GS_SET2]) begin
            current_std = STD_GS;
          end else begin
            current_std = STD_XG;
          end
        end
      end
      byte_pos  = '0;
      live_mask = ALL_ALIVE;
    end else begin
      // saturate the position so overlong messages match nothing
      if (byte_pos < LONGEST_PATTERN) byte_pos = byte_pos + 1'b1;
      live_mask = live;
    end
    res.standard = current_std;
  endtask

  always @(posedge clk) begin : watch
    mode_result_t res;
    mode_result_t want;
    if (!rst_n) begin
      lock_q      = 1'b0;
      default_std = STD_GM;
      current_std = STD_GM;
      byte_pos    = '0;
      live_mask   = ALL_ALIVE;
      expected_modes.delete();
      fail_count      = 0;
      results_checked = 0;
      matches_seen    = 0;
    end else begin
      // track register writes
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr >> 2)
          REG_STANDARD_LOCKED: begin
            lock_q = cfg_pwdata[0];
          end
          REG_DEFAULT_STANDARD: begin
            default_std = (cfg_pwdata[1:0] > STD_XG) ? STD_XG : std_t'(cfg_pwdata[1:0]);
            current_std = default_std;
          end
          default: ;
        endcase
      end
      // compare result beat against the oldest expectation
      if (out_bus.valid && out_bus.ready) begin
        if (expected_modes.size() == 0) begin
          flag_mismatch($sformatf("result beat with nothing expected (standard %0d)",
                                  out_bus.midi_standard));
        end else begin
          want = expected_modes.pop_front();
          results_checked++;
          if (want.recognized) matches_seen++;
          if (out_bus.midi_standard !== want.standard) begin
            flag_mismatch($sformatf("midi_standard got %0d, expected %0d (beat %0d)",
                                    out_bus.midi_standard, want.standard, results_checked));
          end
          if (out_bus.recognized !== want.recognized) begin
            flag_mismatch($sformatf("recognized got %0d, expected %0d (beat %0d)",
                                    out_bus.recognized, want.recognized, results_checked));
          end
        end
      end
      // predict the result of an accepted byte beat
      if (in_bus.valid && in_bus.ready) begin
        advance_detector(in_bus.sysex_byte, in_bus.last_byte, res);
        expected_modes.push_back(res);
      end
    end
    pending_results = expected_modes.size();
  end

endmodule

### dv/midi_sysex_mode_detector_core_tb.sv
`timescale 1ns / 100ps

module midi_sysex_mode_detector_core_tb;
  import msmd_pkg::*;

  typedef logic [7:0] sysex_msg_t [$];

  localparam int RANDOM_SEGMENTS = 6;
  localparam int SEGMENT_BYTES   = 64;
  localparam int DRAIN_LIMIT     = 20000;

  localparam logic [7:0] MESSAGE_BYTES [PAT_COUNT][LONGEST_PATTERN] = '{
    '{8'hf0, 8'h7e, 8'h00, 8'h09, 8'h01, 8'hf7, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'hf0, 8'h7e, 8'h00, 8'h09, 8'h02, 8'hf7, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'hf0, 8'h41, 8'h00, 8'h42, 8'h12, 8'h40, 8'h00, 8'h7f, 8'h00, 8'h41, 8'hf7},
    '{8'hf0, 8'h41, 8'h00, 8'h42, 8'h12, 8'h00, 8'h00, 8'h7f, 8'h00, 8'h01, 8'hf7},
    '{8'hf0, 8'h41, 8'h00, 8'h42, 8'h12, 8'h00, 8'h00, 8'h7f, 8'h01, 8'h00, 8'hf7},
    '{8'hf0, 8'h43, 8'h00, 8'h4c, 8'h00, 8'h00, 8'h7e, 8'h00, 8'hf7, 8'h00, 8'h00}
  };

  // Register settings per random segment; defaults include the out-of-range 3
  localparam logic        SEG_LOCK    [RANDOM_SEGMENTS] = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0};
  localparam logic [31:0] SEG_DEFAULT [RANDOM_SEGMENTS] = '{32'd2, 32'd1, 32'd3, 32'd0,
                                                            32'd0, 32'd1};

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [31:0]           cfg_pwdata;
  logic [31:0]           cfg_prdata;
  logic                  cfg_pready;

  int fail_count;
  int pending_results;
  int results_checked;
  int matches_seen;
  int send_idle_pct;
  int recv_idle_pct;
  int bytes_sent;
  int messages_sent;
  int settings_used;

  msmd_in_if  in_bus ();
  msmd_out_if out_bus ();

  midi_sysex_mode_detector_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_bus      (in_bus),
    .out_bus     (out_bus),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  midi_mode_monitor monitor (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_bus          (in_bus),
    .out_bus         (out_bus),
    .cfg_psel        (cfg_psel),
    .cfg_penable     (cfg_penable),
    .cfg_pwrite      (cfg_pwrite),
    .cfg_pready      (cfg_pready),
    .cfg_paddr       (cfg_paddr),
    .cfg_pwdata      (cfg_pwdata),
    .fail_count      (fail_count),
    .pending_results (pending_results),
    .results_checked (results_checked),
    .matches_seen    (matches_seen)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Stall the result channel at random
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Hold one byte beat until the block takes it
  task automatic send_beat(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.sysex_byte <= b;
    in_bus.last_byte  <= last;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_message(input sysex_msg_t msg);
    foreach (msg[i]) send_beat(msg[i], i == msg.size() - 1);
    messages_sent++;
  endtask

  // Drop valid and wait for every result, plus the output stage latency
  task automatic wait_idle();
    in_bus.valid <= 1'b0;
    @(negedge clk);
    while (pending_results != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_register(input logic idx, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_ADDR_W'({idx, 2'b00});
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic apply_setting(input logic lock, input logic [31:0] dflt);
    wait_idle();
    write_register(REG_STANDARD_LOCKED, {31'd0, lock});
    write_register(REG_DEFAULT_STANDARD, dflt);
    settings_used++;
  endtask

  function automatic sysex_msg_t build_pattern(input int k, input logic [7:0] dev_id);
    sysex_msg_t m;
    for (int i = 0; i < PAT_LEN[k]; i++) begin
      m.push_back((i == DEVICE_ID_POS) ? dev_id : MESSAGE_BYTES[k][i]);
    end
    return m;
  endfunction

  // Mostly well-formed patterns with random device IDs, then broken ones and noise
  function automatic sysex_msg_t random_message();
    sysex_msg_t m;
    int pick;
    int n;
    pick = $urandom_range(99);
    if (pick < 72) begin
      m = build_pattern($urandom_range(PAT_COUNT - 1), 8'($urandom_range(255)));
      if (pick >= 52) begin
        case ($urandom_range(2))
          0: m[$urandom_range(m.size() - 1)] = 8'($urandom_range(255));
          1: repeat ($urandom_range(1, m.size() - 1)) void'(m.pop_back());
          default: begin
            n = $urandom_range(1, 7);
            repeat (n) m.push_back($urandom_range(3) == 0 ? 8'hf7 : 8'($urandom_range(255)));
          end
        endcase
      end
    end else begin
      n = $urandom_range(1, 14);
      repeat (n) m.push_back(8'($urandom_range(255)));
    end
    return m;
  endfunction

  initial begin
    sysex_msg_t m;
    int drain;
    rst_n             = 1'b0;
    in_bus.valid      = 1'b0;
    in_bus.sysex_byte = 8'h00;
    in_bus.last_byte  = 1'b0;
    cfg_psel          = 1'b0;
    cfg_penable       = 1'b0;
    cfg_pwrite        = 1'b0;
    cfg_paddr         = '0;
    cfg_pwdata        = '0;
    send_idle_pct     = 9;
    recv_idle_pct     = 86;
    bytes_sent        = 0;
    messages_sent     = 0;
    settings_used     = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // every pattern from reset defaults
    send_message(build_pattern(PAT_GM_ON, 8'h7f));
    send_message(build_pattern(PAT_XG_ON, 8'h00));
    send_message(build_pattern(PAT_GM_OFF, 8'hff));
    send_message(build_pattern(PAT_GS_RST, 8'h10));
    send_message(build_pattern(PAT_GM_ON, 8'h00));
    send_message(build_pattern(PAT_GS_SET1, 8'h7f));
    send_message(build_pattern(PAT_XG_ON, 8'h55));
    send_message(build_pattern(PAT_GS_SET2, 8'haa));
    // lone end byte and raw extremes
    m = '{8'hf7};
    send_message(m);
    m = '{8'h00, 8'hff, 8'h55, 8'haa};
    send_message(m);
    // overlong message saturates the position
    m = build_pattern(PAT_GS_RST, 8'h10);
    repeat (5) m.push_back(8'hf7);
    send_message(m);
    // truncated message one byte short
    m = build_pattern(PAT_GS_RST, 8'h10);
    void'(m.pop_back());
    send_message(m);
    // locked standard with an out-of-range default, then unlocked settings
    apply_setting(1'b1, 32'd3);
    send_message(build_pattern(PAT_GM_ON, 8'h01));
    send_message(build_pattern(PAT_GS_RST, 8'h01));
    apply_setting(1'b0, 32'd3);
    send_message(build_pattern(PAT_GM_ON, 8'h01));
    send_message(build_pattern(PAT_GM_OFF, 8'h01));
    apply_setting(1'b0, 32'd1);
    send_message(build_pattern(PAT_GM_ON, 8'h02));
    send_message(build_pattern(PAT_GM_OFF, 8'h02));

    // random segments, two per idle mix
    for (int seg = 0; seg < RANDOM_SEGMENTS; seg++) begin
      apply_setting(SEG_LOCK[seg], SEG_DEFAULT[seg]);
      case (seg / 2)
        0: begin
          send_idle_pct = 9;
          recv_idle_pct = 86;
        end
        1: begin
          send_idle_pct = 86;
          recv_idle_pct = 9;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      drain = bytes_sent + SEGMENT_BYTES;
      while (bytes_sent < drain) send_message(random_message());
    end

    // drain the remaining results
    in_bus.valid <= 1'b0;
    drain = 0;
    while (pending_results != 0 && drain < DRAIN_LIMIT) begin
      @(negedge clk);
      drain++;
    end
    repeat (4) @(negedge clk);
    if (pending_results != 0) begin
      $display("%0d expected result beats never arrived", pending_results);
    end
    $display("Sent %0d bytes in %0d messages under %0d register settings and three idle mixes.",
             bytes_sent, messages_sent, settings_used);
    $display("Checked %0d result beats, %0d of them recognized patterns.",
             results_checked, matches_seen);
    if (fail_count == 0 && pending_results == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #1600000;
    $display("Timeout waiting for the block");
    $display("Some tests failed");
    $finish;
  end

endmodule
